FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv tokenizer assertion failed");

// Antecedent in one cycle, consequent in the next.
`define CFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `CFT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

FILE: rtl/cft_pkg.sv
package cft_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_REC   = 3'd0,
    PH_FLD   = 3'd1,
    PH_UNQ   = 3'd2,
    PH_QUO   = 3'd3,
    PH_QSEEN = 3'd4
  } cft_phase_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        field_end;
    logic        record_end;
    logic        record_abort;
    logic [15:0] field_length;
  } cft_result_t;

  function automatic logic [15:0] len_inc(input logic [15:0] len);
    len_inc = (len == LEN_MAX) ? len : len + 16'd1;
  endfunction

endpackage

FILE: rtl/cft_parser.sv
module cft_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 func,
  input  logic [7:0]           data_byte,
  output cft_pkg::cft_result_t res
);
  import cft_pkg::*;

  cft_phase_t  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic        is_nl, is_sep, is_quote;

  assign is_nl    = (data_byte == CH_LF) || (data_byte == CH_CR);
  assign is_sep   = is_nl || (data_byte == CH_COMMA);
  assign is_quote = (data_byte == CH_QUOTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_REC;
      len_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    if (func) begin
      phase_nxt = PH_REC;
      len_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_QUO: begin
          if (is_quote) begin
            phase_nxt = PH_QSEEN;
          end else begin
            len_nxt = len_inc(len_r);
          end
        end
        PH_QSEEN: begin
          if (is_quote) begin
            phase_nxt = PH_QUO;
            len_nxt   = len_inc(len_r);
          end else begin
            phase_nxt = is_nl ? PH_REC : PH_FLD;
            len_nxt   = '0;
          end
        end
        PH_UNQ: begin
          if (is_sep) begin
            phase_nxt = is_nl ? PH_REC : PH_FLD;
            len_nxt   = '0;
          end else begin
            len_nxt = len_inc(len_r);
          end
        end
        default: begin
          if ((phase_r != PH_FLD) && is_nl) begin
            phase_nxt = PH_REC;
          end else if (is_sep) begin
            phase_nxt = is_nl ? PH_REC : PH_FLD;
            len_nxt   = '0;
          end else if (is_quote) begin
            phase_nxt = PH_QUO;
            len_nxt   = '0;
          end else begin
            phase_nxt = PH_UNQ;
            len_nxt   = 16'd1;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res = '0;
    if (func) begin
      unique case (phase_r)
        PH_FLD, PH_UNQ, PH_QSEEN: begin
          res.valid        = 1'b1;
          res.field_end    = 1'b1;
          res.record_end   = 1'b1;
          res.field_length = len_r;
        end
        PH_QUO: begin
          res.valid        = 1'b1;
          res.record_abort = 1'b1;
        end
        default: res = '0;
      endcase
    end else begin
      unique case (phase_r)
        PH_QUO: begin
          if (!is_quote) begin
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = data_byte;
          end
        end
        PH_QSEEN: begin
          res.valid = 1'b1;
          if (is_quote) begin
            res.byte_valid = 1'b1;
            res.out_byte   = data_byte;
          end else begin
            res.field_end    = 1'b1;
            res.record_end   = is_nl;
            res.field_length = len_r;
          end
        end
        PH_UNQ: begin
          res.valid = 1'b1;
          if (is_sep) begin
            res.field_end    = 1'b1;
            res.record_end   = is_nl;
            res.field_length = len_r;
          end else begin
            res.byte_valid = 1'b1;
            res.out_byte   = data_byte;
          end
        end
        default: begin
          if ((phase_r != PH_FLD) && is_nl) begin
            res = '0;
          end else if (is_sep) begin
            res.valid        = 1'b1;
            res.field_end    = 1'b1;
            res.record_end   = is_nl;
            res.field_length = len_r;
          end else if (!is_quote) begin
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = data_byte;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/csv_field_tokenizer_core.sv
// Each accepted word is parsed from the input register into the result register.
// One input word per cycle unless stalled; a word may give no result at all.
// Both sides are split by an input register and a result register, so the
// input is stalled only while the result register is full and stalled.
// Reset (rst_n low, synchronous) returns the parser to record start with a
// zero field length and empties both registers.
module csv_field_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_field_end,
  output logic        out_record_end,
  output logic        out_record_abort,
  output logic [15:0] out_field_length
);
  import cft_pkg::*;

  logic        s1_valid_r;
  logic        s1_func_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  cft_result_t res;
  cft_result_t res_r;
  logic        out_ready, s1_adv, in_acc;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_data_byte;
    end
  end

  cft_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .func      (s1_func_r),
    .data_byte (s1_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && out_ready) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = res_r.out_byte;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_field_end    = res_r.field_end;
  assign out_record_end   = res_r.record_end;
  assign out_record_abort = res_r.record_abort;
  assign out_field_length = res_r.field_length;

endmodule

FILE: rtl/cft_checker.sv
`include "assert_macros.svh"

module cft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_byte_valid,
  input logic        out_field_end,
  input logic        out_record_end,
  input logic        out_record_abort,
  input logic [15:0] out_field_length
);

  `CFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_field_length) && $stable(out_field_end))
  `CFT_ASSERT(a_one_kind, clk, rst_n, out_valid |-> $onehot({out_byte_valid, out_field_end, out_record_abort}))
  `CFT_ASSERT(a_rec_in_field, clk, rst_n, (out_valid && out_record_end) |-> out_field_end)
  `CFT_ASSERT(a_len_zero, clk, rst_n, (out_valid && !out_field_end) |-> (out_field_length == 16'd0))

endmodule

bind csv_field_tokenizer_core cft_checker u_cft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_byte_valid   (out_byte_valid),
  .out_field_end    (out_field_end),
  .out_record_end   (out_record_end),
  .out_record_abort (out_record_abort),
  .out_field_length (out_field_length)
);
